[hw/rtl/tcw_pkg.sv]
// Shared codes, field widths and stream word layouts of the text console writer.
`default_nettype none

package tcw_pkg;

   localparam int KIND_W = 3;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 11;
   localparam int CUR_W  = 11;

   localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FILL     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PUT      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PUT_ATTR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ     = 3'd4;

   localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'h20;
   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0a;

   typedef struct packed {
      logic [4:0]        pad;
      logic [IDX_W-1:0]  cell_index;
      logic [BYTE_W-1:0] attr_value;
      logic [BYTE_W-1:0] char_code;
   } req_data_type;

   typedef struct packed {
      logic [3:0]        pad;
      logic              scrolled;
      logic [BYTE_W-1:0] read_attr;
      logic [BYTE_W-1:0] read_char;
      logic [CUR_W-1:0]  cursor_pos;
   } rsp_data_type;

endpackage

`default_nettype wire

[hw/rtl/text_console_writer_unit.sv]
// Top level of the text console writer: request sequencer around the cell stores.
//
// Text console of COLUMNS x ROWS cells, each a character byte and an attribute
// byte held in two RAMs with registered reads, with a cursor register. Every
// request word gives exactly one response word. A put or a read first accepts the
// word (and launches the RAM read), then writes or captures the cell. An unknown
// request goes straight to its response. Clear and fill sweep one store at a cell
// a cycle. A put that finds the cursor past the end first scrolls the character
// store through its write port at a cell a cycle. After reset a clearing pass
// fills both stores before the first request word is taken. The next request is
// taken while the previous response waits in the output register.
`default_nettype none

module text_console_writer_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // char_code [7:0], attr_value [15:8], cell_index [26:16], zero [31:27]
   input  wire logic [31:0] req_tdata,
   // req_type [2:0]
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // cursor_pos [10:0], read_char [18:11], read_attr [26:19], scrolled [27], zero [31:28]
   output logic [31:0]      rsp_tdata
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CELLS + 1);
   localparam int SW    = CW + 1;
   localparam int COLW  = $clog2(COLUMNS);
   localparam int XW    = (CW > tcw_pkg::IDX_W) ? CW : tcw_pkg::IDX_W;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCROLL,
      ST_PUT,
      ST_RDAT,
      ST_CLEAR,
      ST_FILL,
      ST_FIN
   } state_type;

   state_type                       state_ff, state_in;
   logic [CW-1:0]                   scan_ff, scan_in;
   logic [CW-1:0]                   cursor_ff, cursor_in;
   logic [COLW-1:0]                 col_ff, col_in;
   logic [tcw_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [tcw_pkg::BYTE_W-1:0]      char_ff, char_in;
   logic [tcw_pkg::BYTE_W-1:0]      attr_ff, attr_in;
   logic                            inrange_ff, inrange_in;
   logic [tcw_pkg::BYTE_W-1:0]      res_char_ff, res_char_in;
   logic [tcw_pkg::BYTE_W-1:0]      res_attr_ff, res_attr_in;
   logic                            res_scroll_ff, res_scroll_in;
   logic                            shift_valid_ff, shift_valid_in;
   logic [AW-1:0]                   shift_addr_ff, shift_addr_in;
   logic                            shift_mem_ff, shift_mem_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_data_type           rsp_data_ff, rsp_data_in;

   tcw_pkg::req_data_type           req_word;
   logic [XW-1:0]                   idx_ext;
   logic [SW-1:0]                   src_sum;
   logic                            out_free;
   logic                            accept;
   logic                            scan_last;

   logic                            char_we, attr_we;
   logic [AW-1:0]                   char_waddr, attr_waddr;
   logic [tcw_pkg::BYTE_W-1:0]      char_wdata, attr_wdata;
   logic [AW-1:0]                   char_raddr, attr_raddr;
   logic [tcw_pkg::BYTE_W-1:0]      char_rdata, attr_rdata;

   assign req_word  = tcw_pkg::req_data_type'(req_tdata);
   assign idx_ext   = XW'(req_word.cell_index);
   assign src_sum   = SW'(scan_ff) + SW'(COLUMNS);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign scan_last = (scan_ff == CW'(CELLS - 1));

   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_FIN) && out_free);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      cursor_in      = cursor_ff;
      col_in         = col_ff;
      kind_in        = kind_ff;
      char_in        = char_ff;
      attr_in        = attr_ff;
      inrange_in     = inrange_ff;
      res_char_in    = res_char_ff;
      res_attr_in    = res_attr_ff;
      res_scroll_in  = res_scroll_ff;
      shift_valid_in = 1'b0;
      shift_addr_in  = shift_addr_ff;
      shift_mem_in   = shift_mem_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;

      // trailing write of the scroll copy, registered behind its read
      char_we    = shift_valid_ff;
      char_waddr = shift_addr_ff;
      char_wdata = shift_mem_ff ? char_rdata : tcw_pkg::SPACE_CODE;
      attr_we    = 1'b0;
      attr_waddr = scan_ff[AW-1:0];
      attr_wdata = attr_ff;
      char_raddr = idx_ext[AW-1:0];
      attr_raddr = idx_ext[AW-1:0];

      unique case (state_ff)
         ST_INIT: begin
            char_we    = 1'b1;
            char_waddr = scan_ff[AW-1:0];
            char_wdata = tcw_pkg::SPACE_CODE;
            attr_we    = 1'b1;
            attr_wdata = '0;
            if (scan_last) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_IDLE, ST_FIN: begin
            if (state_ff == ST_FIN && out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.pad         = '0;
               rsp_data_in.scrolled    = res_scroll_ff;
               rsp_data_in.read_attr   = res_attr_ff;
               rsp_data_in.read_char   = res_char_ff;
               rsp_data_in.cursor_pos  = tcw_pkg::CUR_W'(cursor_ff);
               state_in                = ST_IDLE;
            end
            if (accept) begin
               kind_in       = req_tuser;
               char_in       = req_word.char_code;
               attr_in       = req_word.attr_value;
               inrange_in    = (idx_ext < XW'(CELLS));
               res_char_in   = '0;
               res_attr_in   = '0;
               res_scroll_in = 1'b0;
               scan_in       = '0;
               unique case (req_tuser)
                  tcw_pkg::KIND_CLEAR: state_in = ST_CLEAR;
                  tcw_pkg::KIND_FILL:  state_in = ST_FILL;
                  tcw_pkg::KIND_PUT, tcw_pkg::KIND_PUT_ATTR: begin
                     state_in = (cursor_ff == CW'(CELLS)) ? ST_SCROLL : ST_PUT;
                  end
                  tcw_pkg::KIND_READ:  state_in = ST_RDAT;
                  default:             state_in = ST_FIN;
               endcase
            end
         end
         ST_SCROLL: begin
            if (scan_ff != CW'(CELLS)) begin
               // read the cell one row below, write it back next cycle
               char_raddr     = src_sum[AW-1:0];
               shift_valid_in = 1'b1;
               shift_addr_in  = scan_ff[AW-1:0];
               shift_mem_in   = (src_sum < SW'(CELLS));
               scan_in        = scan_ff + CW'(1);
            end else begin
               cursor_in     = CW'(CELLS - COLUMNS);
               col_in        = '0;
               res_scroll_in = 1'b1;
               state_in      = ST_PUT;
            end
         end
         ST_PUT: begin
            if (char_ff == tcw_pkg::NEWLINE_CODE) begin
               cursor_in = cursor_ff + CW'(COLUMNS) - CW'(col_ff);
               col_in    = '0;
            end else begin
               char_we    = 1'b1;
               char_waddr = cursor_ff[AW-1:0];
               char_wdata = char_ff;
               attr_we    = (kind_ff == tcw_pkg::KIND_PUT_ATTR);
               attr_waddr = cursor_ff[AW-1:0];
               attr_wdata = attr_ff;
               cursor_in  = cursor_ff + CW'(1);
               col_in     = (col_ff == COLW'(COLUMNS - 1)) ? '0 : col_ff + COLW'(1);
            end
            state_in = ST_FIN;
         end
         ST_RDAT: begin
            if (inrange_ff) begin
               res_char_in = char_rdata;
               res_attr_in = attr_rdata;
            end
            state_in = ST_FIN;
         end
         ST_CLEAR: begin
            char_we    = 1'b1;
            char_waddr = scan_ff[AW-1:0];
            char_wdata = tcw_pkg::SPACE_CODE;
            if (scan_last) begin
               cursor_in = '0;
               col_in    = '0;
               state_in  = ST_FIN;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_FILL: begin
            attr_we = 1'b1;
            if (scan_last) begin
               state_in = ST_FIN;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         scan_ff        <= '0;
         cursor_ff      <= '0;
         col_ff         <= '0;
         shift_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scan_ff        <= scan_in;
         cursor_ff      <= cursor_in;
         col_ff         <= col_in;
         shift_valid_ff <= shift_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      char_ff       <= char_in;
      attr_ff       <= attr_in;
      inrange_ff    <= inrange_in;
      res_char_ff   <= res_char_in;
      res_attr_ff   <= res_attr_in;
      res_scroll_ff <= res_scroll_in;
      shift_addr_ff <= shift_addr_in;
      shift_mem_ff  <= shift_mem_in;
      rsp_data_ff   <= rsp_data_in;
   end

   tcw_ram #(
      .DEPTH (CELLS),
      .WIDTH (tcw_pkg::BYTE_W)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (char_we),
      .wr_addr (char_waddr),
      .wr_data (char_wdata),
      .rd_addr (char_raddr),
      .rd_data (char_rdata)
   );

   tcw_ram #(
      .DEPTH (CELLS),
      .WIDTH (tcw_pkg::BYTE_W)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (attr_waddr),
      .wr_data (attr_wdata),
      .rd_addr (attr_raddr),
      .rd_data (attr_rdata)
   );

endmodule

`default_nettype wire

[hw/rtl/tcw_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module tcw_ram #(
   parameter int DEPTH = 2000,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
